[rtl/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants for the triangle plane clipper
// Coordinate, vertex and word types, distance width and the divider step.
// ----------------------------------------------------------------------------
`default_nettype none
package tpc_pkg;

	localparam int CoordW = 32;
	localparam int NormW = 18;
	localparam int SW = 54;            // signed distance / divider remainder width
	localparam int TF = 16;            // fraction bits of the cut parameter t
	localparam int DIV_ST = 8;         // divider stages
	localparam int DIV_PER = TF / DIV_ST;
	localparam int PW = NormW + CoordW; // distance product width
	localparam int DW = CoordW + 1;    // coordinate difference width
	localparam int MW = TF + 1 + DW;   // interpolation product width

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic signed [NormW-1:0] norm_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vtx_t;

	typedef struct packed {
		coord_t a_x;
		coord_t a_y;
		coord_t a_z;
		coord_t b_x;
		coord_t b_y;
		coord_t b_z;
		coord_t c_x;
		coord_t c_y;
		coord_t c_z;
	} tri_in_t;

	typedef struct packed {
		coord_t o1_x;
		coord_t o1_y;
		coord_t o1_z;
		coord_t o2_x;
		coord_t o2_y;
		coord_t o2_z;
		coord_t o3_x;
		coord_t o3_y;
		coord_t o3_z;
		logic   last_piece;
	} tri_out_t;

	// how a triangle leaves the clipper
	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_FULL = 2'd1,
		MODE_ONE  = 2'd2,
		MODE_TWO  = 2'd3
	} mode_t;

	// vertices carried alongside the divider
	typedef struct packed {
		mode_t mode;
		vtx_t  ca_u;
		vtx_t  ca_w;
		vtx_t  cb_u;
		vtx_t  cb_w;
	} ctx_t;

	// register indexes (byte address / 4)
	localparam logic [1:0] REG_NX = 2'd0;
	localparam logic [1:0] REG_NY = 2'd1;
	localparam logic [1:0] REG_NZ = 2'd2;
	localparam logic [1:0] REG_D  = 2'd3;

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [SW:0] div_step(input logic [SW-1:0] rem,
			input logic [SW-1:0] den);
		logic [SW:0] r2;
		r2 = {rem, 1'b0};
		if (r2 >= {1'b0, den}) begin
			r2 = r2 - {1'b0, den};
			return {1'b1, r2[SW-1:0]};
		end
		return {1'b0, r2[SW-1:0]};
	endfunction

endpackage
`default_nettype wire

[rtl/tpc_div.sv]
// ----------------------------------------------------------------------------
// tpc_div: pipelined restoring divider for the cut parameter
// Produces floor(num * 2^TF / den) for num < den, DIV_PER bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module tpc_div (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [tpc_pkg::SW-1:0]  num,
	input  wire logic [tpc_pkg::SW-1:0]  den,
	output logic      [tpc_pkg::TF-1:0]  quo
);
	import tpc_pkg::*;

	logic [SW-1:0] rem_s [DIV_ST];
	logic [SW-1:0] den_s [DIV_ST];
	logic [TF-1:0] q_s   [DIV_ST];

	// DIV_PER steps per stage, quotient shifts in from the bottom
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_ST; k++) begin
				logic [SW-1:0] r;
				logic [SW-1:0] d;
				logic [TF-1:0] q;
				logic [SW:0]   st;
				r = (k == 0) ? num : rem_s[(k == 0) ? 0 : k-1];
				d = (k == 0) ? den : den_s[(k == 0) ? 0 : k-1];
				q = (k == 0) ? '0  : q_s[(k == 0) ? 0 : k-1];
				for (int j = 0; j < DIV_PER; j++) begin
					st = div_step(r, d);
					r = st[SW-1:0];
					q = {q[TF-2:0], st[SW]};
				end
				rem_s[k] <= r;
				den_s[k] <= d;
				q_s[k]   <= q;
			end
		end
	end

	assign quo = q_s[DIV_ST-1];

endmodule
`default_nettype wire

[rtl/triangle_plane_clip.sv]
// ----------------------------------------------------------------------------
// triangle_plane_clip: clips triangles against the plane n.p >= d
// Top level: config registers, distance, setup, cut and output stages.
// ----------------------------------------------------------------------------
// Usage:
//  triangle channel: one Q16.16 triangle per word (tri_valid / tri_ready).
//  piece channel: zero, one or two clipped triangles per input word,
//   last_piece high on the final one (piece_valid / piece_ready).
//  APB port sets the normal (Q1.16) and the offset d (Q16.16); write only
//   while no triangle is in flight.
//  Path from accept to the first piece: distance products, sum, setup, 8 divider
//   stages, interpolation product, result register. Throughput: one triangle
//   per cycle while piece_ready is high, when it yields at most one piece; a
//   triangle with two pieces holds the input until its second is taken. The
//   result register drives the rate. The pipeline moves as one: when the
//   receiver stalls, every stage holds and tri_ready drops. Reset empties
//   the pipeline and loads the default plane z >= 0.
`default_nettype none
module triangle_plane_clip (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              tri_valid,
	output logic                   tri_ready,
	input  wire tpc_pkg::tri_in_t  triangle,
	output logic                   piece_valid,
	input  wire logic              piece_ready,
	output tpc_pkg::tri_out_t      piece,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [3:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);
	import tpc_pkg::*;

	// config registers
	norm_t  nx_q, ny_q, nz_q;
	coord_t d_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nx_q <= '0;
			ny_q <= '0;
			nz_q <= norm_t'(65536);
			d_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_NX: nx_q <= pwdata[NormW-1:0];
				REG_NY: ny_q <= pwdata[NormW-1:0];
				REG_NZ: nz_q <= pwdata[NormW-1:0];
				REG_D:  d_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NX: prdata = 32'(nx_q);
			REG_NY: prdata = 32'(ny_q);
			REG_NZ: prdata = 32'(nz_q);
			REG_D:  prdata = d_q;
			default: prdata = '0;
		endcase
	end

	// global advance
	logic adv;
	logic res_vld_q;

	assign tri_ready = adv;

	// s1: vertices and distance products
	logic vld_s1;
	vtx_t v_s1 [3];
	logic signed [PW-1:0] pr_s1 [3][3];
	vtx_t vin [3];

	assign vin[0] = '{triangle.a_x, triangle.a_y, triangle.a_z};
	assign vin[1] = '{triangle.b_x, triangle.b_y, triangle.b_z};
	assign vin[2] = '{triangle.c_x, triangle.c_y, triangle.c_z};

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				v_s1[i]     <= vin[i];
				pr_s1[i][0] <= nx_q * vin[i].x;
				pr_s1[i][1] <= ny_q * vin[i].y;
				pr_s1[i][2] <= nz_q * vin[i].z;
			end
		end
	end

	// s2: signed distance of each vertex
	logic vld_s2;
	vtx_t v_s2 [3];
	logic signed [SW-1:0] s_s2 [3];
	logic signed [SW-1:0] off;

	assign off = SW'(d_q) <<< TF;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				v_s2[i] <= v_s1[i];
				s_s2[i] <= SW'(pr_s1[i][0]) + SW'(pr_s1[i][1]) + SW'(pr_s1[i][2]) - off;
			end
		end
	end

	// s3: classify and pick the cut edges
	logic [2:0] kept;
	mode_t mode_n;
	logic [1:0] iau, iaw, ibu, ibw;
	logic [SW-1:0] num_a, den_a, num_b, den_b;
	ctx_t ctx_n, ctx_s3;
	logic vld_s3;
	logic [SW-1:0] na_s3, da_s3, nb_s3, db_s3;

	for (genvar i = 0; i < 3; i++) begin : g_kept
		assign kept[i] = ~s_s2[i][SW-1];
	end

	always_comb begin
		iau = 2'd0; iaw = 2'd2; ibu = 2'd1; ibw = 2'd2;
		mode_n = MODE_NONE;
		case (kept)
			3'b111: mode_n = MODE_FULL;
			3'b001: begin mode_n = MODE_ONE; iau = 2'd0; iaw = 2'd1; ibu = 2'd0; ibw = 2'd2; end
			3'b010: begin mode_n = MODE_ONE; iau = 2'd1; iaw = 2'd0; ibu = 2'd1; ibw = 2'd2; end
			3'b100: begin mode_n = MODE_ONE; iau = 2'd2; iaw = 2'd0; ibu = 2'd2; ibw = 2'd1; end
			3'b110: begin mode_n = MODE_TWO; iau = 2'd1; iaw = 2'd0; ibu = 2'd2; ibw = 2'd0; end
			3'b101: begin mode_n = MODE_TWO; iau = 2'd0; iaw = 2'd1; ibu = 2'd2; ibw = 2'd1; end
			3'b011: begin mode_n = MODE_TWO; iau = 2'd0; iaw = 2'd2; ibu = 2'd1; ibw = 2'd2; end
			default: mode_n = MODE_NONE;
		endcase
	end

	function automatic vtx_t pick_v(input logic [1:0] sel, input vtx_t a, input vtx_t b,
			input vtx_t c);
		case (sel)
			2'd0: return a;
			2'd1: return b;
			default: return c;
		endcase
	endfunction

	function automatic logic [SW-1:0] pick_s(input logic [1:0] sel,
			input logic [SW-1:0] a, input logic [SW-1:0] b, input logic [SW-1:0] c);
		case (sel)
			2'd0: return a;
			2'd1: return b;
			default: return c;
		endcase
	endfunction

	always_comb begin
		ctx_n.mode = mode_n;
		ctx_n.ca_u = pick_v(iau, v_s2[0], v_s2[1], v_s2[2]);
		ctx_n.ca_w = pick_v(iaw, v_s2[0], v_s2[1], v_s2[2]);
		ctx_n.cb_u = pick_v(ibu, v_s2[0], v_s2[1], v_s2[2]);
		ctx_n.cb_w = pick_v(ibw, v_s2[0], v_s2[1], v_s2[2]);
		num_a = pick_s(iau, s_s2[0], s_s2[1], s_s2[2]);
		den_a = num_a - pick_s(iaw, s_s2[0], s_s2[1], s_s2[2]);
		num_b = pick_s(ibu, s_s2[0], s_s2[1], s_s2[2]);
		den_b = num_b - pick_s(ibw, s_s2[0], s_s2[1], s_s2[2]);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= ctx_n;
			na_s3  <= num_a;
			da_s3  <= den_a;
			nb_s3  <= num_b;
			db_s3  <= den_b;
		end
	end

	// divider stages: t for both cuts, context rides alongside
	logic [TF-1:0] ta, tb;
	ctx_t ctx_dv [DIV_ST];
	logic vld_dv [DIV_ST];

	tpc_div u_div_a (.clk(clk), .en(adv), .num(na_s3), .den(da_s3), .quo(ta));
	tpc_div u_div_b (.clk(clk), .en(adv), .num(nb_s3), .den(db_s3), .quo(tb));

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DIV_ST; k++)
				ctx_dv[k] <= (k == 0) ? ctx_s3 : ctx_dv[(k == 0) ? 0 : k-1];
		end
	end

	// s12: interpolation products t * (w - u)
	function automatic logic signed [MW-1:0] cut_mul(input logic [TF-1:0] t,
			input coord_t u, input coord_t w);
		logic signed [DW-1:0] df;
		df = DW'(w) - DW'(u);
		return $signed({1'b0, t}) * df;
	endfunction

	ctx_t ctx_s12;
	logic vld_s12;
	logic signed [MW-1:0] ma_s12 [3];
	logic signed [MW-1:0] mb_s12 [3];
	ctx_t cl;

	assign cl = ctx_dv[DIV_ST-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s12   <= cl;
			ma_s12[0] <= cut_mul(ta, cl.ca_u.x, cl.ca_w.x);
			ma_s12[1] <= cut_mul(ta, cl.ca_u.y, cl.ca_w.y);
			ma_s12[2] <= cut_mul(ta, cl.ca_u.z, cl.ca_w.z);
			mb_s12[0] <= cut_mul(tb, cl.cb_u.x, cl.cb_w.x);
			mb_s12[1] <= cut_mul(tb, cl.cb_u.y, cl.cb_w.y);
			mb_s12[2] <= cut_mul(tb, cl.cb_u.z, cl.cb_w.z);
		end
	end

	// u + floor(prod / 2^TF), saturated
	function automatic coord_t cut_fin(input coord_t u, input logic signed [MW-1:0] m);
		logic signed [MW-TF-1:0] sh;
		logic signed [MW-TF:0]   sm;
		sh = m[MW-1:TF];
		sm = (MW-TF+1)'(u) + (MW-TF+1)'(sh);
		if (sm > (MW-TF+1)'(32'sh7fffffff))
			return 32'sh7fffffff;
		if (sm < -(MW-TF+1)'(33'sh080000000))
			return 32'sh80000000;
		return sm[CoordW-1:0];
	endfunction

	// result register: holds one clipped triangle set
	mode_t res_mode_q;
	vtx_t ra_q, rb_q, rc_q, rp_q, rq_q;
	logic piece_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			res_mode_q <= ctx_s12.mode;
			ra_q <= ctx_s12.ca_u;
			rb_q <= ctx_s12.cb_u;
			rc_q <= ctx_s12.ca_w;
			rp_q <= '{cut_fin(ctx_s12.ca_u.x, ma_s12[0]), cut_fin(ctx_s12.ca_u.y, ma_s12[1]),
				cut_fin(ctx_s12.ca_u.z, ma_s12[2])};
			rq_q <= '{cut_fin(ctx_s12.cb_u.x, mb_s12[0]), cut_fin(ctx_s12.cb_u.y, mb_s12[1]),
				cut_fin(ctx_s12.cb_u.z, mb_s12[2])};
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s12   <= 1'b0;
			res_vld_q <= 1'b0;
			piece_q   <= 1'b0;
			for (int k = 0; k < DIV_ST; k++)
				vld_dv[k] <= 1'b0;
		end else begin
			if (adv) begin
				vld_s1 <= tri_valid;
				vld_s2 <= vld_s1;
				vld_s3 <= vld_s2;
				for (int k = 0; k < DIV_ST; k++)
					vld_dv[k] <= (k == 0) ? vld_s3 : vld_dv[(k == 0) ? 0 : k-1];
				vld_s12   <= vld_dv[DIV_ST-1];
				res_vld_q <= vld_s12 && (ctx_s12.mode != MODE_NONE);
				piece_q   <= 1'b0;
			end else if (piece_valid && piece_ready) begin
				piece_q <= 1'b1;
			end
		end
	end

	// output word select
	function automatic tri_out_t mk_tri(input vtx_t p, input vtx_t q, input vtx_t r,
			input logic last);
		return '{p.x, p.y, p.z, q.x, q.y, q.z, r.x, r.y, r.z, last};
	endfunction

	always_comb begin
		case (res_mode_q)
			MODE_FULL: piece = mk_tri(ra_q, rb_q, rc_q, 1'b1);
			MODE_ONE:  piece = mk_tri(ra_q, rp_q, rq_q, 1'b1);
			default:   piece = piece_q ? mk_tri(rb_q, rq_q, rp_q, 1'b1)
				: mk_tri(ra_q, rb_q, rp_q, 1'b0);
		endcase
	end

	assign piece_valid = res_vld_q;
	assign adv = !res_vld_q || (piece_ready && piece.last_piece);

`ifndef SYNTHESIS
	// a first piece taken is always followed by the closing piece
	a_second_piece: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && piece_ready && !piece.last_piece |=> piece_valid && piece.last_piece)
		else $error("second piece missing after first piece");

	// an empty result register never blocks the input
	a_empty_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!piece_valid |-> tri_ready)
		else $error("pipeline stalled with empty result register");

	// a pending piece with a stalled receiver keeps the pipeline frozen
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		piece_valid && !piece_ready |-> !tri_ready)
		else $error("pipeline moved under a stall");
`endif

endmodule
`default_nettype wire
